// ===== rtl/core/cum_pkg.sv =====
package cum_pkg;

	// Event kinds carried by an input item.
	localparam logic [1:0] KIND_SLOT = 2'd0;
	localparam logic [1:0] KIND_TX   = 2'd1;
	localparam logic [1:0] KIND_ACK  = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// Bits of the action field.
	localparam int unsigned ACT_ADD_BIT = 0;
	localparam int unsigned ACT_DEL_BIT = 1;

	// Configuration register indexes.
	localparam logic [2:0] REG_USAGE_WINDOW = 3'd0;
	localparam logic [2:0] REG_TX_HALVING   = 3'd1;
	localparam logic [2:0] REG_UPPER_PCT    = 3'd2;
	localparam logic [2:0] REG_LOWER_PCT    = 3'd3;
	localparam logic [2:0] REG_ADD_INC      = 3'd4;
	localparam logic [2:0] REG_ALLOW_REMOVE = 3'd5;

	localparam int unsigned CNT_W    = 10;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 10;
	localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

	// Memory port controls shared by both counter tables.
	typedef struct packed {
		logic rd_en;   // read the entry of the item being accepted
		logic wr_en;   // write back the item leaving stage one
		logic clr_en;  // clear one entry during the pass after reset
	} mem_ctl_t;

	// Saturating increment of a counter.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

	// Remainder of a narrow index by a table depth, one restoring step per bit.
	function automatic logic [11:0] wrap_index(input logic [7:0] v, input int unsigned n);
		logic [19:0] r;
		logic [19:0] d;
		r = {12'd0, v};
		for (int k = 7; k >= 0; k--) begin
			d = 20'(n) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[11:0];
	endfunction

endpackage

// ===== rtl/core/cum_evt_if.sv =====
interface cum_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [3:0] neighbor_index;
	logic [7:0] cell_index;
	logic       cell_is_auto;
	logic       cell_is_tx;

	modport source (output valid, kind, neighbor_index, cell_index, cell_is_auto, cell_is_tx,
		input ready);
	modport sink (input valid, kind, neighbor_index, cell_index, cell_is_auto, cell_is_tx,
		output ready);
endinterface

// ===== rtl/core/cum_req_if.sv =====
interface cum_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [3:0] add_count;
	logic [3:0] target_neighbor;
	logic [9:0] cell_tx_count;
	logic [9:0] cell_ack_count;

	modport source (output valid, action, add_count, target_neighbor, cell_tx_count,
		cell_ack_count, input ready);
	modport sink (input valid, action, add_count, target_neighbor, cell_tx_count,
		cell_ack_count, output ready);
endinterface

// ===== rtl/core/cell_usage_monitor.sv =====
// Cell usage monitor: takes one slot event per item and returns exactly one request
// item for it. Per-cell transmit and ack counters and per-neighbor elapsed and used
// counters live in two synchronous tables; an item reads its entries in the cycle it
// is accepted and writes them back as it leaves stage one, with forwarding between
// adjacent items; a new item is taken every cycle unless the request side stalls. After
// reset a clearing pass zeroes both tables, one entry per cycle over the larger of
// CELL_ENTRIES and NEIGHBOR_ENTRIES, during which no item is taken; configuration
// writes are taken at any time and must only be made while idle.
module cell_usage_monitor #(
	parameter int unsigned NEIGHBOR_ENTRIES = 16,
	parameter int unsigned CELL_ENTRIES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	cum_evt_if.sink                         evt,
	cum_req_if.source                       req,
	input  logic                            cfg_we,
	input  logic [cum_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cum_pkg::CFG_DAT_W-1:0]   cfg_data
);

	localparam int unsigned NB_AW = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
	localparam int unsigned CL_AW = (CELL_ENTRIES > 1) ? $clog2(CELL_ENTRIES) : 1;
	localparam int unsigned CLR_N = (CELL_ENTRIES > NEIGHBOR_ENTRIES) ?
		CELL_ENTRIES : NEIGHBOR_ENTRIES;
	localparam int unsigned CLR_W = $clog2(CLR_N);
	localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);

	// Configuration registers.
	logic [9:0] usage_window_q;
	logic [9:0] tx_limit_q;
	logic [6:0] upper_pct_q;
	logic [6:0] lower_pct_q;
	logic [3:0] add_inc_q;
	logic       allow_removal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usage_window_q  <= 10'd100;
			tx_limit_q      <= 10'd256;
			upper_pct_q     <= 7'd75;
			lower_pct_q     <= 7'd25;
			add_inc_q       <= 4'd1;
			allow_removal_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				cum_pkg::REG_USAGE_WINDOW: usage_window_q  <= cfg_data[9:0];
				cum_pkg::REG_TX_HALVING:   tx_limit_q      <= cfg_data[9:0];
				cum_pkg::REG_UPPER_PCT:    upper_pct_q     <= cfg_data[6:0];
				cum_pkg::REG_LOWER_PCT:    lower_pct_q     <= cfg_data[6:0];
				cum_pkg::REG_ADD_INC:      add_inc_q       <= cfg_data[3:0];
				cum_pkg::REG_ALLOW_REMOVE: allow_removal_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clearing pass after reset.
	logic             clr_busy_q;
	logic [CLR_W-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Handshake and stage control.
	logic valid_s1;
	logic out_valid_q;
	logic adv_s1;
	logic accept;

	assign adv_s1    = valid_s1 && (!out_valid_q || req.ready);
	assign evt.ready = !clr_busy_q && (!valid_s1 || adv_s1);
	assign accept    = evt.valid && evt.ready;

	// Table indexes wrap at the table depth.
	logic [11:0]      nb_wrap;
	logic [11:0]      cl_wrap;
	logic [NB_AW-1:0] nb_addr;
	logic [CL_AW-1:0] cl_addr;

	assign nb_wrap = cum_pkg::wrap_index({4'd0, evt.neighbor_index}, NEIGHBOR_ENTRIES);
	assign cl_wrap = cum_pkg::wrap_index(evt.cell_index, CELL_ENTRIES);
	assign nb_addr = nb_wrap[NB_AW-1:0];
	assign cl_addr = cl_wrap[CL_AW-1:0];

	cum_pkg::mem_ctl_t cell_ctl;
	cum_pkg::mem_ctl_t nbr_ctl;

	assign cell_ctl.rd_en  = accept;
	assign cell_ctl.wr_en  = adv_s1;
	assign cell_ctl.clr_en = clr_busy_q && (32'(clr_cnt_q) < CELL_ENTRIES);
	assign nbr_ctl.rd_en   = accept;
	assign nbr_ctl.wr_en   = adv_s1;
	assign nbr_ctl.clr_en  = clr_busy_q && (32'(clr_cnt_q) < NEIGHBOR_ENTRIES);

	// Stage one holds the item whose entries are being read.
	logic [1:0] kind_s1;
	logic [3:0] nb_s1;
	logic       auto_s1;
	logic       is_tx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= evt.kind;
			nb_s1    <= evt.neighbor_index;
			auto_s1  <= evt.cell_is_auto;
			is_tx_s1 <= evt.cell_is_tx;
		end
	end

	logic [9:0] tx_count;
	logic [9:0] ack_count;
	logic [1:0] action;
	logic [3:0] add_count;

	cum_cell_stats #(
		.CELL_ENTRIES(CELL_ENTRIES),
		.AW(CL_AW)
	) u_cell (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(cell_ctl),
		.rd_addr(cl_addr),
		.clr_addr(clr_cnt_q[CL_AW-1:0]),
		.kind_s1(kind_s1),
		.auto_s1(auto_s1),
		.tx_limit(tx_limit_q),
		.tx_count(tx_count),
		.ack_count(ack_count)
	);

	cum_nbr_usage #(
		.NEIGHBOR_ENTRIES(NEIGHBOR_ENTRIES),
		.AW(NB_AW)
	) u_nbr (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(nbr_ctl),
		.rd_addr(nb_addr),
		.clr_addr(clr_cnt_q[NB_AW-1:0]),
		.kind_s1(kind_s1),
		.is_tx_s1(is_tx_s1),
		.usage_window(usage_window_q),
		.upper_pct(upper_pct_q),
		.lower_pct(lower_pct_q),
		.add_inc(add_inc_q),
		.allow_removal(allow_removal_q),
		.action(action),
		.add_count(add_count)
	);

	// Output register holding the request item until it is taken.
	logic [1:0] action_q;
	logic [3:0] add_count_q;
	logic [3:0] target_q;
	logic [9:0] tx_count_q;
	logic [9:0] ack_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (req.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			action_q    <= action;
			add_count_q <= add_count;
			target_q    <= nb_s1;
			tx_count_q  <= tx_count;
			ack_count_q <= ack_count;
		end
	end

	assign req.valid           = out_valid_q;
	assign req.action          = action_q;
	assign req.add_count       = add_count_q;
	assign req.target_neighbor = target_q;
	assign req.cell_tx_count   = tx_count_q;
	assign req.cell_ack_count  = ack_count_q;

endmodule

// ===== rtl/core/cum_cell_stats.sv =====
module cum_cell_stats #(
	parameter int unsigned CELL_ENTRIES = 256,
	parameter int unsigned AW = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cum_pkg::mem_ctl_t             ctl,
	input  logic [AW-1:0]                 rd_addr,
	input  logic [AW-1:0]                 clr_addr,
	input  logic [1:0]                    kind_s1,
	input  logic                          auto_s1,
	input  logic [cum_pkg::CNT_W-1:0]     tx_limit,
	output logic [cum_pkg::CNT_W-1:0]     tx_count,
	output logic [cum_pkg::CNT_W-1:0]     ack_count
);

	localparam int unsigned DW = 2 * cum_pkg::CNT_W;

	logic [DW-1:0] mem [CELL_ENTRIES];
	logic [DW-1:0] rdata_q;
	logic [DW-1:0] fwd_data_q;
	logic          fwd_q;
	logic [AW-1:0] addr_s1;
	logic [DW-1:0] cur;
	logic [DW-1:0] upd;
	logic [cum_pkg::CNT_W-1:0] tx_inc;

	// Current entry: memory data, or the value written back just as it was read.
	assign cur = fwd_q ? fwd_data_q : rdata_q;

	// Counter update of a non-autonomous cell.
	always_comb begin
		tx_inc = cum_pkg::sat_inc(cur[DW-1:cum_pkg::CNT_W]);
		upd = cur;
		if (!auto_s1) begin
			if (kind_s1 == cum_pkg::KIND_TX) begin
				if (tx_inc >= tx_limit) begin
					upd = {1'b0, tx_inc[cum_pkg::CNT_W-1:1], 1'b0,
						cur[cum_pkg::CNT_W-1:1]};
				end else begin
					upd = {tx_inc, cur[cum_pkg::CNT_W-1:0]};
				end
			end else if (kind_s1 == cum_pkg::KIND_ACK) begin
				upd = {cur[DW-1:cum_pkg::CNT_W], cum_pkg::sat_inc(cur[cum_pkg::CNT_W-1:0])};
			end
		end
	end

	assign tx_count  = upd[DW-1:cum_pkg::CNT_W];
	assign ack_count = upd[cum_pkg::CNT_W-1:0];

	// Table with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.clr_en) begin
			mem[clr_addr] <= '0;
		end else if (ctl.wr_en) begin
			mem[addr_s1] <= upd;
		end
		if (ctl.rd_en) begin
			rdata_q    <= mem[rd_addr];
			addr_s1    <= rd_addr;
			fwd_data_q <= upd;
		end
	end

	// Forward when the entry being read is the one written back in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (ctl.rd_en) begin
			fwd_q <= ctl.wr_en && (addr_s1 == rd_addr);
		end
	end

endmodule

// ===== rtl/core/cum_nbr_usage.sv =====
module cum_nbr_usage #(
	parameter int unsigned NEIGHBOR_ENTRIES = 16,
	parameter int unsigned AW = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cum_pkg::mem_ctl_t         ctl,
	input  logic [AW-1:0]             rd_addr,
	input  logic [AW-1:0]             clr_addr,
	input  logic [1:0]                kind_s1,
	input  logic                      is_tx_s1,
	input  logic [cum_pkg::CNT_W-1:0] usage_window,
	input  logic [6:0]                upper_pct,
	input  logic [6:0]                lower_pct,
	input  logic [3:0]                add_inc,
	input  logic                      allow_removal,
	output logic [1:0]                action,
	output logic [3:0]                add_count
);

	localparam int unsigned CW = cum_pkg::CNT_W;
	localparam int unsigned DW = 2 * CW;
	localparam int unsigned PW = 17;

	logic [DW-1:0] mem [NEIGHBOR_ENTRIES];
	logic [DW-1:0] rdata_q;
	logic [DW-1:0] fwd_data_q;
	logic          fwd_q;
	logic [AW-1:0] addr_s1;
	logic [DW-1:0] cur;
	logic [DW-1:0] upd;
	logic [CW-1:0] el;
	logic [CW-1:0] us;
	logic          assess;
	logic [PW-1:0] used100;
	logic [PW-1:0] upper_prod;
	logic [PW-1:0] lower_prod;

	assign cur = fwd_q ? fwd_data_q : rdata_q;

	// Count elapsed and used TX cells, then judge usage once the window is full.
	always_comb begin
		el = cur[DW-1:CW];
		us = cur[CW-1:0];
		if (is_tx_s1 && kind_s1 == cum_pkg::KIND_SLOT) begin
			el = cum_pkg::sat_inc(cur[DW-1:CW]);
		end
		if (is_tx_s1 && kind_s1 == cum_pkg::KIND_TX) begin
			us = cum_pkg::sat_inc(cur[CW-1:0]);
		end
		assess     = is_tx_s1 && (kind_s1 != cum_pkg::KIND_NONE) && (el >= usage_window);
		used100    = PW'(us) * PW'(100);
		upper_prod = PW'(upper_pct) * PW'(el);
		lower_prod = PW'(lower_pct) * PW'(el);
		action     = '0;
		add_count  = '0;
		if (assess && used100 >= upper_prod && add_inc != '0) begin
			action[cum_pkg::ACT_ADD_BIT] = 1'b1;
			add_count = add_inc;
		end
		if (assess && used100 <= lower_prod && allow_removal) begin
			action[cum_pkg::ACT_DEL_BIT] = 1'b1;
		end
		upd = assess ? '0 : {el, us};
	end

	// Table with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.clr_en) begin
			mem[clr_addr] <= '0;
		end else if (ctl.wr_en) begin
			mem[addr_s1] <= upd;
		end
		if (ctl.rd_en) begin
			rdata_q    <= mem[rd_addr];
			addr_s1    <= rd_addr;
			fwd_data_q <= upd;
		end
	end

	// Forward when the entry being read is the one written back in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (ctl.rd_en) begin
			fwd_q <= ctl.wr_en && (addr_s1 == rd_addr);
		end
	end

endmodule

// ===== dv/tb.sv =====
module tb;
	import cum_pkg::*;

	localparam int unsigned CYCLE_LIMIT      = 1_000_000;
	localparam int unsigned ITEMS_PER_PHASE  = 12;
	localparam int unsigned CFG_PHASES       = 7;
	localparam int unsigned SATURATION_PHASE = 2;
	localparam int unsigned HOLD_PHASE       = 3;
	localparam int unsigned HOLD_CYCLES      = 300;
	localparam int unsigned SETTLE_CYCLES    = 4;
	localparam int unsigned MAX_REPORTS      = 10;

	// Action code of a request that asks for nothing.
	localparam logic [1:0] ACT_NONE = 2'b00;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] neighbor;
		logic [7:0] cell_idx;
		logic       is_auto;
		logic       is_tx;
	} slot_evt_t;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] add_count;
		logic [3:0] target;
		logic [9:0] tx_count;
		logic [9:0] ack_count;
	} usage_req_t;

	typedef struct packed {
		slot_evt_t  ev;
		logic       known;
		usage_req_t want;
	} dir_row_t;

	typedef struct packed {
		logic [9:0] window;
		logic [9:0] halving;
		logic [6:0] upper;
		logic [6:0] lower;
		logic [3:0] inc;
		logic       removal;
	} usage_cfg_t;

	localparam usage_req_t NO_WANT = '0;
	localparam usage_cfg_t RESET_CFG = '{10'd100, 10'd256, 7'd75, 7'd25, 4'd1, 1'b1};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	cum_evt_if evt ();
	cum_req_if req ();

	cell_usage_monitor #(
		.NEIGHBOR_ENTRIES(16),
		.CELL_ENTRIES(256)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: configuration copy and the four counter tables.
	usage_cfg_t cfg;
	logic [9:0] cell_tx_tab [256];
	logic [9:0] cell_ack_tab [256];
	logic [9:0] nb_elapsed [16];
	logic [9:0] nb_used [16];

	usage_req_t pending_requests [$];
	int unsigned bad_requests = 0;
	int unsigned cycle_count = 0;
	bit hold_off_req = 1'b0;

	// Directed items under the reset configuration. Rows marked known carry a
	// result that can be read straight off the counters; the rest are predicted.
	dir_row_t directed_rows [15] = '{
		'{'{KIND_SLOT, 4'd0, 8'd0, 1'b0, 1'b0}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd0, 10'd0, 10'd0}},
		'{'{KIND_TX, 4'd15, 8'd255, 1'b0, 1'b1}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd15, 10'd1, 10'd0}},
		'{'{KIND_ACK, 4'd15, 8'd255, 1'b0, 1'b1}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd15, 10'd1, 10'd1}},
		'{'{KIND_NONE, 4'd15, 8'd255, 1'b0, 1'b1}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd15, 10'd1, 10'd1}},
		'{'{KIND_TX, 4'd15, 8'd255, 1'b1, 1'b1}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd15, 10'd1, 10'd1}},
		'{'{KIND_ACK, 4'd15, 8'd255, 1'b1, 1'b0}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd15, 10'd1, 10'd1}},
		'{'{KIND_NONE, 4'd0, 8'd0, 1'b1, 1'b0}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd0, 10'd0, 10'd0}},
		'{'{KIND_SLOT, 4'd8, 8'd128, 1'b0, 1'b1}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd8, 10'd0, 10'd0}},
		'{'{KIND_TX, 4'd8, 8'd128, 1'b0, 1'b0}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd8, 10'd1, 10'd0}},
		'{'{KIND_ACK, 4'd8, 8'd128, 1'b0, 1'b1}, 1'b1,
			'{ACT_NONE, 4'd0, 4'd8, 10'd1, 10'd1}},
		'{'{KIND_TX, 4'd1, 8'd1, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{'{KIND_ACK, 4'd2, 8'd2, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{'{KIND_SLOT, 4'd7, 8'd127, 1'b1, 1'b1}, 1'b0, NO_WANT},
		'{'{KIND_TX, 4'd7, 8'd127, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{'{KIND_NONE, 4'd9, 8'd200, 1'b0, 1'b0}, 1'b0, NO_WANT}
	};

	// Counter increment that sticks at the ceiling.
	function automatic logic [9:0] count_up(input logic [9:0] v);
		return (v >= CNT_MAX) ? CNT_MAX : v + 10'd1;
	endfunction

	function automatic void clear_usage_model();
		cfg = RESET_CFG;
		foreach (cell_tx_tab[i]) begin
			cell_tx_tab[i] = '0;
			cell_ack_tab[i] = '0;
		end
		foreach (nb_elapsed[i]) begin
			nb_elapsed[i] = '0;
			nb_used[i] = '0;
		end
	endfunction

	// Updates the counters for one slot event and returns the request it yields.
	function automatic usage_req_t predict_request(input slot_evt_t e);
		usage_req_t r;
		int unsigned used100;
		int unsigned elapsed;
		r = '0;
		r.target = e.neighbor;
		if (e.kind != KIND_NONE) begin
			// Per-cell statistics are kept only for cells that are not autonomous.
			if (!e.is_auto) begin
				if (e.kind == KIND_TX) begin
					cell_tx_tab[e.cell_idx] = count_up(cell_tx_tab[e.cell_idx]);
					if (cell_tx_tab[e.cell_idx] >= cfg.halving) begin
						cell_tx_tab[e.cell_idx] = cell_tx_tab[e.cell_idx] >> 1;
						cell_ack_tab[e.cell_idx] = cell_ack_tab[e.cell_idx] >> 1;
					end
				end else if (e.kind == KIND_ACK) begin
					cell_ack_tab[e.cell_idx] = count_up(cell_ack_tab[e.cell_idx]);
				end
			end
			// Neighbor usage; an ack still runs the window check.
			if (e.is_tx) begin
				if (e.kind == KIND_SLOT) begin
					nb_elapsed[e.neighbor] = count_up(nb_elapsed[e.neighbor]);
				end else if (e.kind == KIND_TX) begin
					nb_used[e.neighbor] = count_up(nb_used[e.neighbor]);
				end
				if (nb_elapsed[e.neighbor] >= cfg.window) begin
					used100 = int'(nb_used[e.neighbor]) * 100;
					elapsed = int'(nb_elapsed[e.neighbor]);
					if (used100 >= int'(cfg.upper) * elapsed && cfg.inc != 0) begin
						r.action[ACT_ADD_BIT] = 1'b1;
						r.add_count = cfg.inc;
					end
					if (used100 <= int'(cfg.lower) * elapsed && cfg.removal) begin
						r.action[ACT_DEL_BIT] = 1'b1;
					end
					nb_elapsed[e.neighbor] = '0;
					nb_used[e.neighbor] = '0;
				end
			end
		end
		r.tx_count = cell_tx_tab[e.cell_idx];
		r.ack_count = cell_ack_tab[e.cell_idx];
		return r;
	endfunction

	// Mostly no gap at all, some short ones, a few long ones.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Events crowd onto a few neighbors and cells so windows close and counters
	// climb; the rest spread over the whole index range.
	function automatic slot_evt_t random_event();
		slot_evt_t e;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			e.kind = KIND_SLOT;
		end else if (r < 75) begin
			e.kind = KIND_TX;
		end else if (r < 95) begin
			e.kind = KIND_ACK;
		end else begin
			e.kind = KIND_NONE;
		end
		e.neighbor = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
		e.cell_idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
		e.is_auto = ($urandom_range(0, 4) == 0);
		e.is_tx = ($urandom_range(0, 3) != 0);
		return e;
	endfunction

	function automatic usage_cfg_t random_config();
		usage_cfg_t c;
		c.window = 10'($urandom_range(1, 30));
		c.halving = 10'($urandom_range(2, 40));
		c.upper = 7'($urandom_range(0, 100));
		c.lower = 7'($urandom_range(0, 100));
		c.inc = 4'($urandom_range(0, 15));
		c.removal = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Offers one item and holds it until taken; valid stays high afterwards.
	task automatic send_event(input slot_evt_t e, input logic known, input usage_req_t want);
		usage_req_t predicted;
		evt.valid <= 1'b1;
		evt.kind <= e.kind;
		evt.neighbor_index <= e.neighbor;
		evt.cell_index <= e.cell_idx;
		evt.cell_is_auto <= e.is_auto;
		evt.cell_is_tx <= e.is_tx;
		do @(posedge clk); while (!evt.ready);
		predicted = predict_request(e);
		pending_requests.insert(pending_requests.size(), known ? want : predicted);
	endtask

	task automatic rest_sender();
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			evt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) begin
			send_event(random_event(), 1'b0, NO_WANT);
			rest_sender();
		end
	endtask

	// Stops offering and waits until every request has come back.
	task automatic settle();
		evt.valid <= 1'b0;
		while (pending_requests.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic apply_config(input usage_cfg_t c);
		write_reg(REG_USAGE_WINDOW, c.window);
		write_reg(REG_TX_HALVING, c.halving);
		write_reg(REG_UPPER_PCT, CFG_DAT_W'(c.upper));
		write_reg(REG_LOWER_PCT, CFG_DAT_W'(c.lower));
		write_reg(REG_ADD_INC, CFG_DAT_W'(c.inc));
		write_reg(REG_ALLOW_REMOVE, CFG_DAT_W'(c.removal));
		cfg_we <= 1'b0;
		cfg = c;
	endtask

	// Runs the same event many times back to back.
	task automatic repeat_event(input slot_evt_t e, input int unsigned count);
		repeat (count) send_event(e, 1'b0, NO_WANT);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls, long ready stretches, and one long hold-off.
	initial begin
		int unsigned stall;
		int unsigned run;
		req.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = idle_len();
			end
			if (stall != 0) begin
				req.ready <= 1'b0;
				for (int n = 0; n < stall; n++) @(posedge clk);
			end
			req.ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
			repeat (run) @(posedge clk);
		end
	end

	// Compare each returned item with the oldest prediction.
	always @(posedge clk) begin
		usage_req_t got;
		usage_req_t want;
		if (arst_n && req.valid && req.ready) begin
			got = '{req.action, req.add_count, req.target_neighbor, req.cell_tx_count,
				req.cell_ack_count};
			if (pending_requests.size() == 0) begin
				if (bad_requests < MAX_REPORTS) begin
					$display("unexpected request: action %0d add %0d nb %0d tx %0d ack %0d",
						got.action, got.add_count, got.target, got.tx_count, got.ack_count);
				end
				bad_requests++;
			end else begin
				want = pending_requests.pop_front();
				if (got !== want) begin
					if (bad_requests < MAX_REPORTS) begin
						$display("request mismatch: action %0d/%0d add %0d/%0d nb %0d/%0d tx %0d/%0d ack %0d/%0d (expected/actual)",
							want.action, got.action, want.add_count, got.add_count,
							want.target, got.target, want.tx_count, got.tx_count,
							want.ack_count, got.ack_count);
					end
					bad_requests++;
				end
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cell_usage_monitor regression: fail");
			$finish;
		end
	end

	initial begin
		usage_cfg_t plan [CFG_PHASES];
		slot_evt_t burst;
		plan[0] = '{10'd1, 10'd2, 7'd0, 7'd0, 4'd15, 1'b1};
		plan[1] = '{10'd0, 10'd0, 7'd127, 7'd127, 4'd0, 1'b0};
		plan[2] = '{10'd1023, 10'd1023, 7'd100, 7'd100, 4'd1, 1'b1};
		plan[3] = '{10'd8, 10'd1, 7'd50, 7'd30, 4'd7, 1'b1};
		plan[4] = '{10'd20, 10'd64, 7'd90, 7'd10, 4'd3, 1'b0};
		plan[5] = random_config();
		plan[6] = random_config();

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		evt.valid <= 1'b0;
		evt.kind <= KIND_SLOT;
		evt.neighbor_index <= '0;
		evt.cell_index <= '0;
		evt.cell_is_auto <= 1'b0;
		evt.cell_is_tx <= 1'b0;
		clear_usage_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset configuration, then random ones.
		foreach (directed_rows[i]) begin
			send_event(directed_rows[i].ev, directed_rows[i].known, directed_rows[i].want);
			rest_sender();
		end
		send_random(ITEMS_PER_PHASE);
		settle();

		for (int p = 0; p < CFG_PHASES; p++) begin
			apply_config(plan[p]);
			if (p == SATURATION_PHASE) begin
				// Drive the ack counter of one cell to its ceiling and past it.
				burst = '{KIND_ACK, 4'd6, 8'd9, 1'b0, 1'b0};
				repeat_event(burst, 1025);
			end
			if (p == HOLD_PHASE) begin
				// Keep offering while the result side holds off, so the block backs up.
				hold_off_req = 1'b1;
				while (hold_off_req) @(posedge clk);
				repeat (48) send_event(random_event(), 1'b0, NO_WANT);
			end
			send_random(ITEMS_PER_PHASE);
			settle();
		end

		repeat (8) @(posedge clk);
		if (bad_requests == 0 && pending_requests.size() == 0) begin
			$display("cell_usage_monitor regression: pass");
		end else begin
			$display("cell_usage_monitor regression: fail");
		end
		$finish;
	end

endmodule
